>>> hdl/ssd_pkg.sv
package ssd_pkg;

  // Default number of digits on the display.
  localparam int NumDigitsDefault = 3;

  // The enable bus is fixed at three digits.
  localparam int EnableW = 3;

  // Blank pattern for a digit (all segments off, active low).
  localparam logic [7:0] Blank = 8'hFF;

  // All digit enables high, so every digit is dark.
  localparam logic [EnableW-1:0] EnableOff = {EnableW{1'b1}};

  // Command codes.
  typedef enum logic [2:0] {
    CMD_TICK  = 3'd0,
    CMD_RAW   = 3'd1,
    CMD_NUM   = 3'd2,
    CMD_CHAR  = 3'd3,
    CMD_CLEAR = 3'd4
  } cmd_t;

  // Input word.
  typedef struct packed {
    logic [2:0] cmd;
    logic [1:0] digit_index;
    logic [7:0] value;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic [7:0]         segments_n;
    logic [EnableW-1:0] digit_enable_n;
  } out_word_t;

  // Segment pattern for a decimal digit; codes above nine come out blank.
  function automatic logic [7:0] digit_shape(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'd0:    s = 8'hC0;
      4'd1:    s = 8'hF9;
      4'd2:    s = 8'hA4;
      4'd3:    s = 8'hB0;
      4'd4:    s = 8'h99;
      4'd5:    s = 8'h92;
      4'd6:    s = 8'h82;
      4'd7:    s = 8'hF8;
      4'd8:    s = 8'h80;
      4'd9:    s = 8'h90;
      default: s = Blank;
    endcase
    return s;
  endfunction

  // Segment pattern for a letter, A being zero; letters without a shape are blank.
  function automatic logic [7:0] letter_shape(input logic [4:0] l);
    logic [7:0] s;
    case (l)
      5'd0:    s = 8'h88;
      5'd1:    s = 8'h83;
      5'd2:    s = 8'hC6;
      5'd3:    s = 8'hA1;
      5'd4:    s = 8'h86;
      5'd5:    s = 8'h8E;
      5'd6:    s = 8'hC2;
      5'd7:    s = 8'h89;
      5'd8:    s = 8'hCF;
      5'd9:    s = 8'hE1;
      5'd11:   s = 8'hC7;
      5'd13:   s = 8'hAB;
      5'd14:   s = 8'hC0;
      5'd15:   s = 8'h8C;
      5'd17:   s = 8'hAF;
      5'd18:   s = 8'h92;
      5'd19:   s = 8'h87;
      5'd20:   s = 8'hC1;
      5'd21:   s = 8'hE3;
      5'd24:   s = 8'h91;
      default: s = Blank;
    endcase
    return s;
  endfunction

  // Segment pattern for an ASCII character, case-insensitive.
  function automatic logic [7:0] char_shape(input logic [7:0] c);
    logic [7:0] u;
    logic [7:0] s;
    u = c;
    if (c >= 8'h61 && c <= 8'h7A) begin
      u = c - 8'h20;
    end
    if (u >= 8'h30 && u <= 8'h39) begin
      s = digit_shape(4'(u - 8'h30));
    end else if (u >= 8'h41 && u <= 8'h5A) begin
      s = letter_shape(5'(u - 8'h41));
    end else begin
      s = Blank;
    end
    return s;
  endfunction

endpackage

>>> hdl/ssd_in_reg.sv
module ssd_in_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  ssd_pkg::in_word_t in_word,
  input  logic             take,
  output logic             held_valid,
  output ssd_pkg::in_word_t held_word
);

  logic              held_valid_r;
  logic              held_valid_nxt;
  ssd_pkg::in_word_t held_word_r;

  // The register is free when empty or when its word moves on this cycle.
  assign in_stall = held_valid_r && !take;

  always_comb begin
    held_valid_nxt = held_valid_r;
    if (!in_stall) begin
      held_valid_nxt = in_valid;
    end
  end

  // Valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_valid_r <= 1'b0;
    end else begin
      held_valid_r <= held_valid_nxt;
    end
  end

  // Input word capture.
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      held_word_r <= in_word;
    end
  end

  assign held_valid = held_valid_r;
  assign held_word  = held_word_r;

endmodule

>>> hdl/ssd_engine.sv
module ssd_engine #(
  parameter int NUM_DIGITS = ssd_pkg::NumDigitsDefault
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              held_valid,
  input  ssd_pkg::in_word_t held_word,
  output logic              take,
  output logic              out_valid,
  input  logic              out_stall,
  output ssd_pkg::out_word_t out_word
);

  localparam int ScanW = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
  localparam logic [ScanW-1:0] ScanLast = ScanW'(NUM_DIGITS - 1);

  logic [7:0]                  pattern_r   [NUM_DIGITS];
  logic [7:0]                  pattern_nxt [NUM_DIGITS];
  logic [ScanW-1:0]            scan_r;
  logic [ScanW-1:0]            scan_nxt;
  logic [7:0]                  seg_r;
  logic [7:0]                  seg_nxt;
  logic [ssd_pkg::EnableW-1:0] en_r;
  logic [ssd_pkg::EnableW-1:0] en_nxt;
  logic                        out_valid_r;
  logic                        out_valid_nxt;
  logic                        advance;
  logic                        idx_ok;
  logic [7:0]                  wr_data;
  logic                        wr_en;

  // The result register can load when empty or when its word is taken.
  assign advance = !out_valid_r || !out_stall;
  assign take    = held_valid && advance;

  assign idx_ok = int'(held_word.digit_index) < NUM_DIGITS;

  // Write data and enable for the three write commands.
  always_comb begin
    wr_data = held_word.value;
    wr_en   = 1'b0;
    case (held_word.cmd)
      ssd_pkg::CMD_RAW: begin
        wr_en = idx_ok;
      end
      ssd_pkg::CMD_NUM: begin
        wr_data = ssd_pkg::digit_shape(held_word.value[3:0]);
        wr_en   = idx_ok && (held_word.value <= 8'd9);
      end
      ssd_pkg::CMD_CHAR: begin
        wr_data = ssd_pkg::char_shape(held_word.value);
        wr_en   = idx_ok;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // Next state for the pattern store, the scan position and the drive.
  always_comb begin
    pattern_nxt = pattern_r;
    scan_nxt    = scan_r;
    seg_nxt     = seg_r;
    en_nxt      = en_r;
    if (take) begin
      unique case (held_word.cmd)
        ssd_pkg::CMD_TICK: begin
          seg_nxt = pattern_r[scan_r];
          en_nxt  = ssd_pkg::EnableOff;
          if (int'(scan_r) < ssd_pkg::EnableW) begin
            en_nxt[scan_r] = 1'b0;
          end
          scan_nxt = (scan_r == ScanLast) ? '0 : scan_r + ScanW'(1);
        end
        ssd_pkg::CMD_CLEAR: begin
          for (int i = 0; i < NUM_DIGITS; i++) begin
            pattern_nxt[i] = ssd_pkg::Blank;
          end
          seg_nxt = ssd_pkg::Blank;
          en_nxt  = ssd_pkg::EnableOff;
        end
        default: begin
          for (int i = 0; i < NUM_DIGITS; i++) begin
            if (wr_en && int'(held_word.digit_index) == i) begin
              pattern_nxt[i] = wr_data;
            end
          end
        end
      endcase
    end
  end

  // Result valid follows the input register whenever the result register loads.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = held_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
        pattern_r[i] <= ssd_pkg::Blank;
      end
      scan_r      <= '0;
      seg_r       <= ssd_pkg::Blank;
      en_r        <= ssd_pkg::EnableOff;
      out_valid_r <= 1'b0;
    end else begin
      pattern_r   <= pattern_nxt;
      scan_r      <= scan_nxt;
      seg_r       <= seg_nxt;
      en_r        <= en_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // The held drive is the result word; it only changes when a new word loads.
  assign out_valid               = out_valid_r;
  assign out_word.segments_n     = seg_r;
  assign out_word.digit_enable_n = en_r;

endmodule

>>> hdl/seven_segment_mux_driver.sv
// Channel  Ports                             Word type            Direction
// input    in_valid, in_stall, in_word       ssd_pkg::in_word_t   into block
// result   out_valid, out_stall, out_word    ssd_pkg::out_word_t  out of block
//
// Every input word gives one result word after the input and result registers.
// One word is accepted per cycle while the result side does not stall; the
// two registers form a two-stage pipeline, the drive state updated between them.
// Synchronous active-low reset blanks all digits, parks the scan at digit zero
// and turns the drive off. A stall on the result side holds the result
// register and back-pressures the input once the input register is full.
module seven_segment_mux_driver #(
  parameter int NUM_DIGITS = ssd_pkg::NumDigitsDefault
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ssd_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output ssd_pkg::out_word_t out_word
);

  logic              held_valid;
  ssd_pkg::in_word_t held_word;
  logic              take;

  // Input register.
  ssd_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .take       (take),
    .held_valid (held_valid),
    .held_word  (held_word)
  );

  // Pattern store, scan and drive with the result register.
  ssd_engine #(
    .NUM_DIGITS (NUM_DIGITS)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .held_valid (held_valid),
    .held_word  (held_word),
    .take       (take),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word)
  );

endmodule
